// ===== src/pwc_pkg.sv =====
package pwc_pkg;

    localparam int unsigned CNT_W       = 8;
    localparam int unsigned TIME_OUT_W  = 32;
    localparam int unsigned INCR_W      = 8;

    localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
    localparam logic [INCR_W-1:0] INCR_RESET = 8'd8;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_READ = 1'b1
    } t_func;

    typedef struct packed {
        t_func func;
        logic  pin_level;
    } t_item;

    // packed so the first field lands in the high bits
    typedef struct packed {
        logic [CNT_W-1:0]      overflow_count;
        logic [TIME_OUT_W-1:0] time_ms;
        logic [CNT_W-1:0]      ticks_since_fall;
        logic [CNT_W-1:0]      pulse_ticks;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== src/pwc_state.sv =====
module pwc_state
    import pwc_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_item             i_item,
    input  logic [INCR_W-1:0] i_incr,
    output t_result           o_result
);

    logic [TIME_WIDTH-1:0] r_elapsed, n_elapsed;
    logic                  r_level, n_level;
    logic [CNT_W-1:0]      r_run, n_run;
    logic [CNT_W-1:0]      r_capt, n_capt;
    logic [CNT_W-1:0]      r_since, n_since;
    logic [CNT_W-1:0]      r_lost, n_lost;
    logic [CNT_W-1:0]      w_pulse;
    logic [63:0]           w_time_ext;

    always_comb begin
        n_elapsed = r_elapsed;
        n_level   = r_level;
        n_run     = r_run;
        n_capt    = r_capt;
        n_since   = r_since;
        n_lost    = r_lost;
        w_pulse   = '0;
        case (i_item.func)
            FUNC_TICK: begin
                n_elapsed = r_elapsed + TIME_WIDTH'(i_incr);
                n_since   = sat_inc(r_since);
                if (i_item.pin_level) begin
                    n_level = 1'b1;
                    n_run   = r_level ? sat_inc(r_run) : CNT_W'(1);
                end else if (r_level) begin
                    // falling edge: capture, count a capture lost unread
                    if (r_capt != '0) begin
                        n_lost = sat_inc(r_lost);
                    end
                    n_level = 1'b0;
                    n_since = '0;
                    n_capt  = r_run;
                end
            end
            FUNC_READ: begin
                w_pulse = r_capt;
                n_capt  = '0;
            end
            default: begin
                w_pulse = '0;
            end
        endcase
    end

    assign w_time_ext = 64'(n_elapsed);

    always_comb begin
        o_result.pulse_ticks      = w_pulse;
        o_result.ticks_since_fall = n_since;
        o_result.time_ms          = w_time_ext[TIME_OUT_W-1:0];
        o_result.overflow_count   = n_lost;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_level   <= 1'b0;
            r_run     <= '0;
            r_capt    <= '0;
            r_since   <= '0;
            r_lost    <= '0;
        end else if (i_step) begin
            r_elapsed <= n_elapsed;
            r_level   <= n_level;
            r_run     <= n_run;
            r_capt    <= n_capt;
            r_since   <= n_since;
            r_lost    <= n_lost;
        end
    end

endmodule

// ===== src/pulse_width_capture_core.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: pin_level; tuser: func
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: pulse_ticks, ticks_since_fall,
//                                              time_ms, overflow_count
// cfg       in   i_cfg_we (no wait)            i_cfg_wdata: tick_increment_ms
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes the input register, then the state update into the result register.
// Reset (synchronous, active low) clears all counters and sets the increment to 8.
// A stalled output holds its result; the input register keeps taking items
// as long as the result register can move on.
module pulse_width_capture_core
    import pwc_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [INCR_W-1:0]   i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [0] pin_level, [7:1] zero
    input  logic [0:0]          s_axis_tuser,   // [0] func
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [7:0] pulse_ticks, [15:8] ticks_since_fall, [47:16] time_ms,
    // [55:48] overflow_count
    output logic [RESULT_W-1:0] m_axis_tdata
);

    logic [INCR_W-1:0] r_incr;
    logic              r_in_valid;
    t_item             r_in;
    logic              r_out_valid;
    t_result           r_result;
    t_result           w_result;
    logic              w_advance;
    logic              w_load;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_load        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_incr <= INCR_RESET;
        end else if (i_cfg_we) begin
            r_incr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.func      <= t_func'(s_axis_tuser[0]);
            r_in.pin_level <= s_axis_tdata[0];
        end
    end

    pwc_state #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_load),
        .i_item   (r_in),
        .i_incr   (r_incr),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= w_result;
        end
    end

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input register empty but not ready");

    a_tick_no_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.func == FUNC_TICK) |-> (w_result.pulse_ticks == '0))
        else $error("tick item shows a captured pulse");

    a_lost_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && w_load) |=>
            (r_result.overflow_count >= $past(r_result.overflow_count)))
        else $error("lost-capture count went down");

endmodule

// ===== bench/tb_pulse_width_capture_core.sv =====
module tb_pulse_width_capture_core;
    import pwc_pkg::*;

    localparam int unsigned TIME_W          = 32;
    localparam int unsigned ITEMS_PER_PHASE = 325;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [INCR_W-1:0]   i_cfg_wdata   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = '0;    // [0] pin_level, [7:1] zero
    logic [0:0]          s_axis_tuser  = '0;    // [0] func
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [7:0] pulse_ticks, [15:8] ticks_since_fall, [47:16] time_ms,
    // [55:48] overflow_count
    logic [RESULT_W-1:0] m_axis_tdata;

    // Tracks the capture state and holds the results still owed by the block.
    class capture_tracker;
        logic [INCR_W-1:0] incr_ms;
        logic [TIME_W-1:0] elapsed;
        logic              was_high;
        logic [CNT_W-1:0]  run_len;
        logic [CNT_W-1:0]  held_len;
        logic [CNT_W-1:0]  since_fall;
        logic [CNT_W-1:0]  lost;
        logic [CNT_W-1:0]  peak_run;
        t_result           pending_results[$];
        int unsigned       n_items;
        int unsigned       n_reads;
        int unsigned       n_pulses_read;
        int unsigned       n_results;
        int unsigned       n_errors;

        function new();
            incr_ms       = INCR_RESET;
            elapsed       = '0;
            was_high      = 1'b0;
            run_len       = '0;
            held_len      = '0;
            since_fall    = '0;
            lost          = '0;
            peak_run      = '0;
            n_items       = 0;
            n_reads       = 0;
            n_pulses_read = 0;
            n_results     = 0;
            n_errors      = 0;
        endfunction

        function logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] v);
            return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
        endfunction

        function void take_item(input t_func f, input logic pin);
            t_result want;
            want = '0;
            n_items++;
            if (f == FUNC_TICK) begin
                elapsed    = elapsed + TIME_W'(incr_ms);
                since_fall = sat_up(since_fall);
                if (pin) begin
                    run_len  = was_high ? sat_up(run_len) : CNT_W'(1);
                    was_high = 1'b1;
                    if (run_len > peak_run)
                        peak_run = run_len;
                end else if (was_high) begin
                    // falling edge: an unread capture is lost
                    if (held_len != 0)
                        lost = sat_up(lost);
                    was_high   = 1'b0;
                    since_fall = '0;
                    held_len   = run_len;
                end
            end else begin
                n_reads++;
                want.pulse_ticks = held_len;
                if (held_len != 0)
                    n_pulses_read++;
                held_len = '0;
            end
            want.ticks_since_fall = since_fall;
            want.time_ms          = TIME_OUT_W'(elapsed);
            want.overflow_count   = lost;
            pending_results.push_back(want);
        endfunction

        function void check_result(input t_result got);
            t_result want;
            n_results++;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("result %0d: unexpected, got %h", n_results, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.pulse_ticks !== want.pulse_ticks
                    || got.ticks_since_fall !== want.ticks_since_fall
                    || got.time_ms !== want.time_ms
                    || got.overflow_count !== want.overflow_count) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("result %0d: expected pulse %0d fall %0d time %0d lost %0d",
                             n_results, want.pulse_ticks, want.ticks_since_fall,
                             want.time_ms, want.overflow_count);
                    $display("result %0d: got      pulse %0d fall %0d time %0d lost %0d",
                             n_results, got.pulse_ticks, got.ticks_since_fall,
                             got.time_ms, got.overflow_count);
                end
            end
        endfunction
    endclass

    capture_tracker tracker;
    bit             src_idle       = 1'b0;
    int unsigned    sink_stall_pct = 0;
    int unsigned    ready_hold     = 0;
    int unsigned    n_settings     = 1;

    pulse_width_capture_core #(
        .TIME_WIDTH(TIME_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 92)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // Sink side: check each accepted result, stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(t_result'(m_axis_tdata));
        if (ready_hold != 0)
            ready_hold--;
        else if ($urandom_range(99) < sink_stall_pct)
            ready_hold = gap_len();
        m_axis_tready <= (ready_hold == 0);
    end

    task automatic send_item(input t_func f, input logic pin);
        int unsigned gap;
        gap = (src_idle && $urandom_range(99) < 35) ? gap_len() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, pin};
        s_axis_tuser  <= f;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_item(f, pin);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_increment(input logic [INCR_W-1:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        tracker.incr_ms = v;
        n_settings++;
    endtask

    // High run, then low run, then maybe a read; a read can also land mid-pulse.
    task automatic pulse_segment(input int unsigned hi_len, input int unsigned lo_len,
                                 input int unsigned read_pct, input bit mid_read);
        for (int unsigned i = 0; i < hi_len; i++) begin
            if (mid_read && i == hi_len / 2)
                send_item(FUNC_READ, 1'($urandom_range(1)));
            send_item(FUNC_TICK, 1'b1);
        end
        for (int unsigned i = 0; i < lo_len; i++)
            send_item(FUNC_TICK, 1'b0);
        if ($urandom_range(99) < read_pct)
            send_item(FUNC_READ, 1'($urandom_range(1)));
    endtask

    function automatic int unsigned run_len_pick();
        return ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(5, 20);
    endfunction

    // long_kind: 1 = pulse long enough to saturate, 2 = long low stretch
    task automatic run_phase(input int unsigned n, input int unsigned long_kind);
        int unsigned stop_at;
        int unsigned kind;
        stop_at = tracker.n_items + n;
        if (long_kind == 1)
            pulse_segment(256 + $urandom_range(20), $urandom_range(1, 8), 100, 1'b0);
        else if (long_kind == 2)
            pulse_segment($urandom_range(1, 3), 256 + $urandom_range(10), 100, 1'b0);
        while (tracker.n_items < stop_at) begin
            src_idle = ($urandom_range(99) < 75);
            case ($urandom_range(3))
                0: sink_stall_pct = 0;
                1: sink_stall_pct = 10;
                2: sink_stall_pct = 30;
                default: sink_stall_pct = 60;
            endcase
            kind = $urandom_range(99);
            if (kind < 70) begin
                pulse_segment(run_len_pick(), run_len_pick(), 20, 1'b0);
            end else if (kind < 85) begin
                pulse_segment(run_len_pick(), run_len_pick(), 50, 1'b1);
            end else begin
                repeat ($urandom_range(1, 12))
                    send_item($urandom_range(1) ? FUNC_READ : FUNC_TICK,
                              1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        #20_000_000;
        $display("** pulse_width_capture_core: FAILED **");
        $finish;
    end

    initial begin
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty reads, single and multi-tick pulses, a read mid-pulse
        send_item(FUNC_READ, 1'b0);
        send_item(FUNC_READ, 1'b1);
        send_item(FUNC_TICK, 1'b0);
        send_item(FUNC_TICK, 1'b1);
        send_item(FUNC_TICK, 1'b0);
        send_item(FUNC_READ, 1'b0);
        send_item(FUNC_TICK, 1'b1);
        send_item(FUNC_TICK, 1'b1);
        send_item(FUNC_TICK, 1'b1);
        send_item(FUNC_TICK, 1'b0);
        send_item(FUNC_TICK, 1'b1);
        send_item(FUNC_READ, 1'b0);
        send_item(FUNC_TICK, 1'b0);
        send_item(FUNC_READ, 1'b1);
        send_item(FUNC_READ, 1'b0);
        send_item(FUNC_TICK, 1'b0);
        send_item(FUNC_TICK, 1'b1);
        send_item(FUNC_READ, 1'b1);
        send_item(FUNC_TICK, 1'b0);
        send_item(FUNC_READ, 1'b0);

        run_phase(ITEMS_PER_PHASE - 20, 0);
        load_increment(8'd0);
        run_phase(ITEMS_PER_PHASE, 0);
        load_increment(8'd255);
        run_phase(ITEMS_PER_PHASE, 1);
        load_increment(8'd1);
        run_phase(ITEMS_PER_PHASE, 0);
        load_increment(INCR_W'($urandom_range(2, 254)));
        run_phase(ITEMS_PER_PHASE, 2);
        load_increment(INCR_W'($urandom_range(0, 255)));
        run_phase(ITEMS_PER_PHASE, 0);

        wait_drained();
        repeat (6) @(posedge i_clk);
        $display("%0d items over %0d increment settings, %0d reads, %0d pulses read back",
                 tracker.n_items, n_settings, tracker.n_reads, tracker.n_pulses_read);
        $display("longest run %0d ticks, lost captures %0d, mismatches %0d",
                 tracker.peak_run, tracker.lost, tracker.n_errors);
        if (tracker.n_errors == 0 && tracker.pending_results.size() == 0)
            $display("** pulse_width_capture_core: PASSED **");
        else
            $display("** pulse_width_capture_core: FAILED **");
        $finish;
    end

endmodule
